[hw/rtl/tsac_pkg.sv]
// Shared types, register indices and reset constants for the three-axis stepped
// attitude corrector. No dependencies; every other file in hw/rtl imports it.
`timescale 1ns / 1ps

package tsac_pkg;

    localparam int unsigned ACCEL_W    = 16;
    localparam int unsigned BAND_W     = 15;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CNT_W      = 9;
    localparam int unsigned LIMIT_W    = 18;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef logic signed [ACCEL_W-1:0] accel_t;
    typedef logic [BAND_W-1:0]         band_t;
    typedef logic [BYTE_W-1:0]         byte_t;
    typedef logic [CNT_W-1:0]          cnt_t;
    typedef logic signed [LIMIT_W-1:0] limit_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_X    = 3'd0,
        REG_TARGET_Y    = 3'd1,
        REG_TARGET_Z    = 3'd2,
        REG_BAND_X      = 3'd3,
        REG_BAND_Y      = 3'd4,
        REG_BAND_Z      = 3'd5,
        REG_HOLD_CYCLES = 3'd6,
        REG_HOVER_POWER = 3'd7
    } cfg_index_t;

    localparam accel_t TARGET_RST  = 16'sd0;
    localparam band_t  BAND_X_RST  = 15'd2000;
    localparam band_t  BAND_Y_RST  = 15'd1200;
    localparam band_t  BAND_Z_RST  = 15'd1200;
    localparam byte_t  HOLD_RST    = 8'd10;
    localparam byte_t  HOVER_RST   = 8'd120;
    localparam byte_t  ANGLE_RST   = 8'd90;
    localparam byte_t  POWER_RST   = 8'd120;
    localparam byte_t  STEP        = 8'd10;
    localparam byte_t  ANGLE_MAX   = 8'd180;
    localparam byte_t  POWER_MAX   = 8'd255;

    // Control passed to the per-axis hold tracker.
    typedef struct packed {
        logic step;
        logic moved;
    } hold_ctl_t;

endpackage

[hw/rtl/tsac_hold.sv]
// Per-axis hold tracker: hold flag and wait counter that gate corrections.
// Depends on tsac_pkg.
`timescale 1ns / 1ps

module tsac_hold (
    input  logic               aclk,
    input  logic               aresetn,
    input  tsac_pkg::hold_ctl_t ctl,
    input  tsac_pkg::byte_t    hold_cycles,
    output logic               holding
);
    import tsac_pkg::*;

    logic hold_reg;
    logic hold_next;
    cnt_t cnt_reg;
    cnt_t cnt_next;

    always_comb begin
        hold_next = hold_reg;
        cnt_next  = cnt_reg;
        if (ctl.step) begin
            if (hold_reg) begin
                if (cnt_reg > {1'b0, hold_cycles}) begin
                    hold_next = 1'b0;
                    cnt_next  = cnt_t'(1);
                end else begin
                    cnt_next = cnt_reg + cnt_t'(1);
                end
            end else begin
                hold_next = ctl.moved;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            hold_reg <= hold_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign holding = hold_reg;

endmodule

[hw/rtl/three_axis_stepped_attitude_corrector.sv]
// Top level of the three-axis stepped attitude corrector: configuration registers,
// axis step logic and the result register. Depends on tsac_pkg and tsac_hold.
`timescale 1ns / 1ps

// The block takes one accelerometer beat per clock while s_ready is high and
// returns exactly one result beat for each, on the m_ ports from the next cycle; the
// single result register holds it, and s_ready drops only while that register holds
// a result that has not been taken. Angles move in steps of ten degrees within 0 to
// 180 and the motor power in steps of ten within 0 to 255, or to hover_power inside
// the Z band; after a change an axis holds for a number of samples set by hold_cycles.
// The user writes configuration registers through cfg_wr_en, cfg_index and cfg_wdata
// while no beat is in flight; the block itself does not enforce this.
module three_axis_stepped_attitude_corrector (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tsac_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tsac_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tsac_pkg::accel_t                    s_accel_x,
    input  tsac_pkg::accel_t                    s_accel_y,
    input  tsac_pkg::accel_t                    s_accel_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tsac_pkg::byte_t                     m_x_angle,
    output tsac_pkg::byte_t                     m_y_angle,
    output tsac_pkg::byte_t                     m_z_power,
    output logic                                m_x_moved,
    output logic                                m_y_moved,
    output logic                                m_z_moved
);
    import tsac_pkg::*;

    function automatic limit_t ext_target(input accel_t t);
        return $signed({{(LIMIT_W-ACCEL_W){t[ACCEL_W-1]}}, t});
    endfunction

    function automatic limit_t ext_band(input band_t b);
        return $signed({{(LIMIT_W-BAND_W){1'b0}}, b});
    endfunction

    function automatic byte_t servo_next(input byte_t ang, input logic below,
                                         input logic above);
        byte_t res;
        res = ang;
        if (below) begin
            res = (ang > ANGLE_MAX - STEP) ? ANGLE_MAX : ang + STEP;
        end else if (above) begin
            res = (ang < STEP) ? '0 : ang - STEP;
        end
        return res;
    endfunction

    accel_t target_x_reg;
    accel_t target_y_reg;
    accel_t target_z_reg;
    band_t  band_x_reg;
    band_t  band_y_reg;
    band_t  band_z_reg;
    byte_t  hold_cycles_reg;
    byte_t  hover_power_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_x_reg    <= TARGET_RST;
            target_y_reg    <= TARGET_RST;
            target_z_reg    <= TARGET_RST;
            band_x_reg      <= BAND_X_RST;
            band_y_reg      <= BAND_Y_RST;
            band_z_reg      <= BAND_Z_RST;
            hold_cycles_reg <= HOLD_RST;
            hover_power_reg <= HOVER_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                REG_TARGET_X:    target_x_reg    <= cfg_wdata;
                REG_TARGET_Y:    target_y_reg    <= cfg_wdata;
                REG_TARGET_Z:    target_z_reg    <= cfg_wdata;
                REG_BAND_X:      band_x_reg      <= cfg_wdata[BAND_W-1:0];
                REG_BAND_Y:      band_y_reg      <= cfg_wdata[BAND_W-1:0];
                REG_BAND_Z:      band_z_reg      <= cfg_wdata[BAND_W-1:0];
                REG_HOLD_CYCLES: hold_cycles_reg <= cfg_wdata[BYTE_W-1:0];
                REG_HOVER_POWER: hover_power_reg <= cfg_wdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    logic  accept;
    logic  m_valid_reg;
    byte_t angle_x_reg;
    byte_t angle_y_reg;
    byte_t power_reg;
    byte_t angle_x_next;
    byte_t angle_y_next;
    byte_t power_next;
    logic  hold_x;
    logic  hold_y;
    logic  hold_z;
    logic  moved_x;
    logic  moved_y;
    logic  moved_z;
    limit_t acc_x;
    limit_t acc_y;
    limit_t acc_z;
    logic  x_below;
    logic  x_above;
    logic  y_below;
    logic  y_above;
    logic  z_below;
    logic  z_inside;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        acc_x    = ext_target(s_accel_x);
        acc_y    = ext_target(s_accel_y);
        acc_z    = ext_target(s_accel_z);
        x_below  = acc_x < ext_target(target_x_reg) - ext_band(band_x_reg);
        x_above  = acc_x > ext_target(target_x_reg) + ext_band(band_x_reg);
        y_below  = acc_y < ext_target(target_y_reg) - ext_band(band_y_reg);
        y_above  = acc_y > ext_target(target_y_reg) + ext_band(band_y_reg);
        z_below  = acc_z < ext_target(target_z_reg) - ext_band(band_z_reg);
        z_inside = !z_below &&
                   (acc_z < ext_target(target_z_reg) + ext_band(band_z_reg));

        angle_x_next = hold_x ? angle_x_reg : servo_next(angle_x_reg, x_below, x_above);
        angle_y_next = hold_y ? angle_y_reg : servo_next(angle_y_reg, y_below, y_above);

        power_next = power_reg;
        if (!hold_z) begin
            if (z_below) begin
                power_next = (power_reg > POWER_MAX - STEP) ? POWER_MAX : power_reg + STEP;
            end else if (z_inside) begin
                power_next = hover_power_reg;
            end else begin
                power_next = (power_reg < STEP) ? '0 : power_reg - STEP;
            end
        end

        moved_x = angle_x_next != angle_x_reg;
        moved_y = angle_y_next != angle_y_reg;
        moved_z = power_next != power_reg;
    end

    tsac_hold u_hold_x (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         ('{step: accept, moved: moved_x}),
        .hold_cycles (hold_cycles_reg),
        .holding     (hold_x)
    );

    tsac_hold u_hold_y (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         ('{step: accept, moved: moved_y}),
        .hold_cycles (hold_cycles_reg),
        .holding     (hold_y)
    );

    tsac_hold u_hold_z (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         ('{step: accept, moved: moved_z}),
        .hold_cycles (hold_cycles_reg),
        .holding     (hold_z)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_x_reg <= ANGLE_RST;
            angle_y_reg <= ANGLE_RST;
            power_reg   <= POWER_RST;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                angle_x_reg <= angle_x_next;
                angle_y_reg <= angle_y_next;
                power_reg   <= power_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    byte_t m_x_angle_reg;
    byte_t m_y_angle_reg;
    byte_t m_z_power_reg;
    logic  m_x_moved_reg;
    logic  m_y_moved_reg;
    logic  m_z_moved_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_x_angle_reg <= angle_x_next;
            m_y_angle_reg <= angle_y_next;
            m_z_power_reg <= power_next;
            m_x_moved_reg <= moved_x;
            m_y_moved_reg <= moved_y;
            m_z_moved_reg <= moved_z;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_x_angle = m_x_angle_reg;
    assign m_y_angle = m_y_angle_reg;
    assign m_z_power = m_z_power_reg;
    assign m_x_moved = m_x_moved_reg;
    assign m_y_moved = m_y_moved_reg;
    assign m_z_moved = m_z_moved_reg;

endmodule

[hw/rtl/tsac_checker.sv]
// Port-level checker for the attitude corrector and the bind that attaches it.
// Depends on tsac_pkg and three_axis_stepped_attitude_corrector.
`timescale 1ns / 1ps

module tsac_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input tsac_pkg::byte_t m_x_angle,
    input tsac_pkg::byte_t m_y_angle,
    input tsac_pkg::byte_t m_z_power,
    input logic            m_x_moved,
    input logic            m_y_moved,
    input logic            m_z_moved
);
    import tsac_pkg::*;

    // A stalled result beat keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_x_angle) && $stable(m_y_angle)
            && $stable(m_z_power) && $stable(m_x_moved) && $stable(m_y_moved)
            && $stable(m_z_moved))
        else $error("result beat changed while stalled");

    // Every accepted sample produces a result beat in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted sample gave no result beat");

    // With the result register empty the input side must be open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no pending result");

    // Servo angles stay within their mechanical range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_x_angle <= ANGLE_MAX && m_y_angle <= ANGLE_MAX)
        else $error("servo angle out of range");

endmodule

bind three_axis_stepped_attitude_corrector tsac_checker u_tsac_checker (.*);
